>>> rtl/tus_pkg.sv
// Package for the triangle uniform subdivider: payload structs, queue entry type,
// reciprocal and vertex-count tables. No dependencies.
package tus_pkg;

   localparam int MAX_DIVISION = 6;
   localparam int RECIP_SHIFT  = 28;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int LOCAL_W      = 5;
   localparam int T_W          = 21;
   localparam int RECIP_W      = 28;
   localparam int PROD_W       = T_W + RECIP_W;

   typedef struct packed {
      logic               new_mesh;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] bz;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
   } tri_in_type;

   typedef struct packed {
      logic               is_triangle;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic [31:0]        vertex_number;
      logic [31:0]        corner_one;
      logic [31:0]        corner_two;
      logic [31:0]        corner_three;
      logic               last;
   } tri_out_type;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] bz;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic [2:0]         div;
      logic [31:0]        offset;
   } job_type;

   // ceil(2^RECIP_SHIFT / (2*n))
   function automatic logic [RECIP_W-1:0] recip(input logic [2:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         3'd1:    r = 28'd134217728;
         3'd2:    r = 28'd67108864;
         3'd3:    r = 28'd44739243;
         3'd4:    r = 28'd33554432;
         3'd5:    r = 28'd26843546;
         3'd6:    r = 28'd22369622;
         default: r = 28'd134217728;
      endcase
      return r;
   endfunction

   // (n+1)(n+2)/2
   function automatic logic [LOCAL_W-1:0] vert_count(input logic [2:0] n);
      logic [LOCAL_W-1:0] v;
      case (n)
         3'd1:    v = 5'd3;
         3'd2:    v = 5'd6;
         3'd3:    v = 5'd10;
         3'd4:    v = 5'd15;
         3'd5:    v = 5'd21;
         3'd6:    v = 5'd28;
         default: v = 5'd3;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/tus_front.sv
// Front end: division count register, input acceptance, vertex offset tracking.
// Depends on tus_pkg.
module tus_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tus_pkg::tri_in_type req_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_data,
   input  logic                queue_full,
   output logic                push,
   output tus_pkg::job_type    job
);

   logic [2:0]  div_ff;
   logic [31:0] offset_ff;
   logic [2:0]  div_c;
   logic [31:0] base;

   assign req_ready = !queue_full;
   assign csr_ready = 1'b1;
   assign push      = req_valid && req_ready;

   always_comb begin
      if (div_ff == 3'd0) begin
         div_c = 3'd1;
      end else if (32'(div_ff) > tus_pkg::MAX_DIVISION) begin
         div_c = 3'(tus_pkg::MAX_DIVISION);
      end else begin
         div_c = div_ff;
      end
      base = req_data.new_mesh ? 32'd0 : offset_ff;
      job.ax     = req_data.ax;
      job.ay     = req_data.ay;
      job.az     = req_data.az;
      job.bx     = req_data.bx;
      job.by     = req_data.by;
      job.bz     = req_data.bz;
      job.cx     = req_data.cx;
      job.cy     = req_data.cy;
      job.cz     = req_data.cz;
      job.div    = div_c;
      job.offset = base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff    <= 3'd1;
         offset_ff <= 32'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            div_ff <= csr_data;
         end
         if (push) begin
            offset_ff <= base + 32'(tus_pkg::vert_count(div_c));
         end
      end
   end

endmodule

>>> rtl/tus_queue.sv
// Short job queue between front and back ends.
// Depends on tus_pkg.
module tus_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tus_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output tus_pkg::job_type head_job
);

   tus_pkg::job_type                 q_ff [tus_pkg::QUEUE_DEPTH];
   logic [tus_pkg::QPTR_W-1:0]       wr_ff;
   logic [tus_pkg::QPTR_W-1:0]       rd_ff;
   logic [tus_pkg::QPTR_W:0]         cnt_ff;

   assign full     = cnt_ff == (tus_pkg::QPTR_W+1)'(tus_pkg::QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign head_job = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            q_ff[wr_ff] <= push_job;
            wr_ff       <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/tus_back.sv
// Back end: result sequencer, interpolation pipeline (s1, s2), output register.
// Depends on tus_pkg.
module tus_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   output logic                 pop,
   input  tus_pkg::job_type     head_job,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tus_pkg::tri_out_type rsp_data
);

   typedef enum logic {PH_VERT, PH_TRI} phase_type;

   function automatic logic [tus_pkg::T_W-1:0] coord_t(
      input logic signed [15:0] a, input logic signed [15:0] b,
      input logic signed [15:0] c, input logic [2:0] n,
      input logic [2:0] r, input logic [2:0] j);
      logic signed [23:0] s;
      logic signed [23:0] t;
      s = 24'(a) * signed'(24'(n - r)) + 24'(b) * signed'(24'(r - j))
        + 24'(c) * signed'(24'(j));
      t = s * 24'sd2 + signed'(24'(n)) * 24'sd131073;
      return tus_pkg::T_W'(t);
   endfunction

   logic                          en;
   logic                          step;
   logic                          busy_ff;
   phase_type                     phase_ff;
   tus_pkg::job_type              cur_ff;
   logic [2:0]                    r_ff, j_ff, i_ff, k_ff;
   logic                          half_ff;
   logic [tus_pkg::LOCAL_W-1:0]   vcnt_ff, pv_ff, nx_ff;

   logic [tus_pkg::LOCAL_W-1:0]   c1, c2, c3;
   logic                          tri_done;

   logic                          s1_valid_ff, s1_tri_ff, s1_last_ff;
   logic [tus_pkg::T_W-1:0]       s1_t_ff [3];
   logic [tus_pkg::RECIP_W-1:0]   s1_rc_ff;
   logic [tus_pkg::LOCAL_W-1:0]   s1_c_ff [3];
   logic [tus_pkg::LOCAL_W-1:0]   s1_v_ff;
   logic [31:0]                   s1_off_ff;

   logic                          s2_valid_ff, s2_tri_ff, s2_last_ff;
   logic [tus_pkg::PROD_W-1:0]    s2_p_ff [3];
   logic [tus_pkg::LOCAL_W-1:0]   s2_c_ff [3];
   logic [tus_pkg::LOCAL_W-1:0]   s2_v_ff;
   logic [31:0]                   s2_off_ff;

   logic                          out_valid_ff;
   tus_pkg::tri_out_type          out_ff;

   assign en        = !out_valid_ff || rsp_ready;
   assign step      = busy_ff && en;
   assign pop       = !busy_ff && !empty && en;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      if (i_ff == 3'd1) begin
         c1 = 5'd0;
         c2 = 5'd1;
         c3 = 5'd2;
         tri_done = cur_ff.div == 3'd1;
      end else if (k_ff != i_ff) begin
         c1 = pv_ff + 5'(k_ff) - 5'd1;
         c2 = half_ff ? nx_ff + 5'(k_ff) : nx_ff + 5'(k_ff) - 5'd1;
         c3 = half_ff ? pv_ff + 5'(k_ff) : nx_ff + 5'(k_ff);
         tri_done = 1'b0;
      end else begin
         c1 = nx_ff + 5'(i_ff);
         c2 = pv_ff + 5'(i_ff) - 5'd1;
         c3 = nx_ff + 5'(i_ff) - 5'd1;
         tri_done = i_ff == cur_ff.div;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_VERT;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            cur_ff   <= head_job;
            busy_ff  <= 1'b1;
            phase_ff <= PH_VERT;
            r_ff     <= 3'd0;
            j_ff     <= 3'd0;
            vcnt_ff  <= '0;
         end
         if (en) begin
            s1_valid_ff <= step;
            s1_off_ff   <= cur_ff.offset;
            s1_rc_ff    <= tus_pkg::recip(cur_ff.div);
            s1_t_ff[0]  <= coord_t(cur_ff.ax, cur_ff.bx, cur_ff.cx, cur_ff.div, r_ff, j_ff);
            s1_t_ff[1]  <= coord_t(cur_ff.ay, cur_ff.by, cur_ff.cy, cur_ff.div, r_ff, j_ff);
            s1_t_ff[2]  <= coord_t(cur_ff.az, cur_ff.bz, cur_ff.cz, cur_ff.div, r_ff, j_ff);
            s1_v_ff     <= vcnt_ff;
            s1_c_ff[0]  <= c1;
            s1_c_ff[1]  <= c2;
            s1_c_ff[2]  <= c3;
            s1_tri_ff   <= phase_ff == PH_TRI;
            s1_last_ff  <= phase_ff == PH_TRI && tri_done;

            s2_valid_ff <= s1_valid_ff;
            s2_tri_ff   <= s1_tri_ff;
            s2_last_ff  <= s1_last_ff;
            s2_v_ff     <= s1_v_ff;
            s2_off_ff   <= s1_off_ff;
            for (int q = 0; q < 3; q++) begin
               s2_p_ff[q] <= tus_pkg::PROD_W'(s1_t_ff[q]) * tus_pkg::PROD_W'(s1_rc_ff);
               s2_c_ff[q] <= s1_c_ff[q];
            end

            out_valid_ff <= s2_valid_ff;
            out_ff.is_triangle <= s2_tri_ff;
            out_ff.last        <= s2_last_ff;
            if (s2_tri_ff) begin
               out_ff.px            <= '0;
               out_ff.py            <= '0;
               out_ff.pz            <= '0;
               out_ff.vertex_number <= '0;
               out_ff.corner_one    <= s2_off_ff + 32'(s2_c_ff[0]);
               out_ff.corner_two    <= s2_off_ff + 32'(s2_c_ff[1]);
               out_ff.corner_three  <= s2_off_ff + 32'(s2_c_ff[2]);
            end else begin
               out_ff.px <= s2_p_ff[0][tus_pkg::RECIP_SHIFT+15:tus_pkg::RECIP_SHIFT];
               out_ff.py <= s2_p_ff[1][tus_pkg::RECIP_SHIFT+15:tus_pkg::RECIP_SHIFT];
               out_ff.pz <= s2_p_ff[2][tus_pkg::RECIP_SHIFT+15:tus_pkg::RECIP_SHIFT];
               out_ff.vertex_number <= s2_off_ff + 32'(s2_v_ff);
               out_ff.corner_one    <= '0;
               out_ff.corner_two    <= '0;
               out_ff.corner_three  <= '0;
            end
         end
         if (step) begin
            if (phase_ff == PH_VERT) begin
               vcnt_ff <= vcnt_ff + 1'b1;
               if (j_ff != r_ff) begin
                  j_ff <= j_ff + 1'b1;
               end else if (r_ff != cur_ff.div) begin
                  r_ff <= r_ff + 1'b1;
                  j_ff <= 3'd0;
               end else begin
                  phase_ff <= PH_TRI;
                  i_ff     <= 3'd1;
               end
            end else if (tri_done) begin
               busy_ff <= 1'b0;
            end else if (i_ff == 3'd1) begin
               i_ff    <= 3'd2;
               k_ff    <= 3'd1;
               half_ff <= 1'b0;
               pv_ff   <= 5'd1;
               nx_ff   <= 5'd3;
            end else if (k_ff != i_ff) begin
               half_ff <= !half_ff;
               if (half_ff) begin
                  k_ff <= k_ff + 1'b1;
               end
            end else begin
               i_ff    <= i_ff + 1'b1;
               k_ff    <= 3'd1;
               half_ff <= 1'b0;
               pv_ff   <= nx_ff;
               nx_ff   <= nx_ff + 5'(i_ff) + 5'd1;
            end
         end
      end
   end

endmodule

>>> rtl/triangle_uniform_subdivider.sv
// Top level of the triangle uniform subdivider: front end, job queue, back end.
// Depends on tus_pkg, tus_front, tus_queue, tus_back.
//
// Each accepted triangle yields (n+1)(n+2)/2 vertex results followed by n*n
// index triples, one result per cycle from the back-end sequencer while the
// output is not stalled by rsp_ready. A two-entry queue lets the front accept
// triangles while the back end works; results pass through the s1, s2 and
// output registers after the sequencer issues them.
module triangle_uniform_subdivider (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tus_pkg::tri_in_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tus_pkg::tri_out_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_data
);

   logic             push, pop, full, empty;
   tus_pkg::job_type push_job, head_job;

   tus_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .csr_valid, .csr_ready, .csr_data,
      .queue_full(full), .push, .job(push_job)
   );

   tus_queue u_queue (
      .clock, .reset, .push, .push_job, .full, .pop, .empty, .head_job
   );

   tus_back u_back (
      .clock, .reset, .empty, .pop, .head_job, .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

>>> tb/sv/triangle_uniform_subdivider_test.sv
// Testbench for triangle_uniform_subdivider: drives triangles and division counts,
// predicts the vertex and index-triple stream and compares every transfer.
// Depends on tus_pkg and the triangle_uniform_subdivider RTL.
module triangle_uniform_subdivider_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;
   localparam int IN_W        = $bits(tus_pkg::tri_in_type);

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   tus_pkg::tri_in_type  req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   tus_pkg::tri_out_type rsp_data;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [2:0]           csr_data = '0;

   triangle_uniform_subdivider u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   tus_pkg::tri_in_type  pending_tris[$];
   tus_pkg::tri_out_type mesh_expected[$];
   logic [2:0]  div_setting;
   logic [31:0] mesh_offset;
   int          error_count = 0;
   int          idle_pct = 19;
   int          stall_cycles = 0;
   bit          csr_pending = 0;
   logic [2:0]  csr_value;

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic signed [15:0] blend_round(input int n, input int r, input int j,
                                                      input logic signed [15:0] a,
                                                      input logic signed [15:0] b,
                                                      input logic signed [15:0] c);
      longint num, t, d, q;
      num = longint'(n - r) * a + longint'(r - j) * b + longint'(j) * c;
      t = 2 * num + n;
      d = 2 * n;
      q = t / d;
      if ((t % d) != 0 && t < 0) q--;
      return q[15:0];
   endfunction

   function automatic int row_start(input int r);
      return r * (r + 1) / 2;
   endfunction

   task automatic add_triple(input int a, input int b, input int c);
      tus_pkg::tri_out_type o;
      o = '0;
      o.is_triangle = 1;
      o.corner_one = mesh_offset + a;
      o.corner_two = mesh_offset + b;
      o.corner_three = mesh_offset + c;
      mesh_expected = {mesh_expected, o};
   endtask

   task automatic predict_mesh(input tus_pkg::tri_in_type t);
      int n, pv, nx;
      tus_pkg::tri_out_type o;
      n = div_setting;
      if (n < 1) n = 1;
      if (n > tus_pkg::MAX_DIVISION) n = tus_pkg::MAX_DIVISION;
      if (t.new_mesh) mesh_offset = 0;
      for (int r = 0; r <= n; r++)
         for (int j = 0; j <= r; j++) begin
            o = '0;
            o.px = blend_round(n, r, j, t.ax, t.bx, t.cx);
            o.py = blend_round(n, r, j, t.ay, t.by, t.cy);
            o.pz = blend_round(n, r, j, t.az, t.bz, t.cz);
            o.vertex_number = mesh_offset + row_start(r) + j;
            mesh_expected = {mesh_expected, o};
         end
      add_triple(0, 1, 2);
      for (int i = 2; i <= n; i++) begin
         pv = row_start(i - 1);
         nx = row_start(i);
         for (int k = 1; k < i; k++) begin
            add_triple(pv + k - 1, nx + k - 1, nx + k);
            add_triple(pv + k - 1, nx + k, pv + k);
         end
         add_triple(nx + i, pv + i - 1, nx + i - 1);
      end
      mesh_expected[$].last = 1;
      mesh_offset = mesh_offset + row_start(n + 1);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         div_setting <= 3'd1;
         mesh_offset <= 0;
      end else begin
         if (req_valid && req_ready) predict_mesh(req_data);
         if (csr_valid && csr_ready) div_setting = csr_data;
      end
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) csr_valid <= 0;
         else if (!csr_valid && csr_pending) begin
            csr_valid <= 1;
            csr_data <= csr_value;
            csr_pending = 0;
         end
         if (!req_valid || req_ready) begin
            if (pending_tris.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1;
               req_data <= pending_tris.pop_front();
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      tus_pkg::tri_out_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (mesh_expected.size() == 0) report_mismatch("unexpected result");
            else begin
               e = mesh_expected.pop_front();
               if (rsp_data.is_triangle !== e.is_triangle) report_mismatch("is_triangle");
               if (rsp_data.px !== e.px)
                  report_mismatch($sformatf("px %h exp %h", rsp_data.px, e.px));
               if (rsp_data.py !== e.py)
                  report_mismatch($sformatf("py %h exp %h", rsp_data.py, e.py));
               if (rsp_data.pz !== e.pz)
                  report_mismatch($sformatf("pz %h exp %h", rsp_data.pz, e.pz));
               if (rsp_data.vertex_number !== e.vertex_number) report_mismatch("vertex_number");
               if (rsp_data.corner_one !== e.corner_one) report_mismatch("corner_one");
               if (rsp_data.corner_two !== e.corner_two) report_mismatch("corner_two");
               if (rsp_data.corner_three !== e.corner_three) report_mismatch("corner_three");
               if (rsp_data.last !== e.last) report_mismatch("last");
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles > STALL_LIMIT) begin
            $display("FAIL triangle_uniform_subdivider");
            $finish;
         end
      end
   end

   function automatic tus_pkg::tri_in_type rand_tri(input bit extreme);
      tus_pkg::tri_in_type t;
      t = tus_pkg::tri_in_type'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      if (extreme) begin
         t.ax = 16'sh8000; t.bx = 16'sh7fff; t.cx = 16'sh8000;
         t.ay = 16'sh7fff; t.by = 16'sh8000; t.cy = 16'sh7fff;
      end
      t.new_mesh = ($urandom_range(9) == 0);
      return t;
   endfunction

   task automatic drain();
      while (pending_tris.size() > 0 || req_valid || mesh_expected.size() > 0)
         @(negedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_division(input logic [2:0] n);
      csr_value = n;
      csr_pending = 1;
      while (csr_pending || csr_valid) @(negedge clock);
   endtask

   task automatic run_phase(input logic [2:0] n, input int count);
      set_division(n);
      for (int i = 0; i < count; i++) pending_tris = {pending_tris, rand_tri(i % 7 == 0)};
      drain();
   endtask

   initial begin
      tus_pkg::tri_in_type t;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset division, extremes, zero and saturating settings
      t = '0; t.new_mesh = 1;
      pending_tris = {pending_tris, t};
      t = '1; pending_tris = {pending_tris, t};
      pending_tris = {pending_tris, rand_tri(1)};
      drain();
      for (int n = 0; n < 8; n++) begin
         set_division(n[2:0]);
         t = '0;
         t.ax = 16'sh8000; t.ay = 16'sh8000; t.az = 16'sh8000;
         t.bx = 16'sh7fff; t.by = 16'sh7fff; t.bz = 16'sh7fff;
         t.cx = 16'sh0001; t.cy = 16'shffff; t.cz = 16'sh0000;
         pending_tris = {pending_tris, t};
         pending_tris = {pending_tris, rand_tri(0)};
         drain();
      end
      run_phase(3'd6, 30);
      idle_pct = 0;
      run_phase(3'd2, 40);
      idle_pct = 19;
      run_phase(3'd1, 40);
      run_phase(3'd4, 40);
      run_phase(3'd0, 20);
      run_phase(3'd7, 30);
      run_phase(3'd3, 40);
      run_phase(3'd5, 40);
      if (error_count == 0) $display("PASS triangle_uniform_subdivider");
      else $display("FAIL triangle_uniform_subdivider");
      $finish;
   end
endmodule
